// ----- hdl/issue_timing_scoreboard_defines.svh -----
// Assertion macros shared by the issue timing scoreboard RTL.
`ifndef ISSUE_TIMING_SCOREBOARD_DEFINES_SVH
`define ISSUE_TIMING_SCOREBOARD_DEFINES_SVH

// Same-cycle implication, reset masked.
`define ITS_ASSERT_SAME(name, clk_s, rst_s, trig, expr, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define ITS_ASSERT_NEXT(name, clk_s, rst_s, trig, expr, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ----- hdl/its_pkg.sv -----
// Types, constants and helper functions for the issue timing scoreboard.
package its_pkg;

  localparam int TIME_W    = 32;
  localparam int ADDR_W    = 48;
  localparam int REG_IDX_W = 3;
  localparam int MEM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int RETIRED_W = 3;

  localparam int WINDOW_DEPTH_DEF = 4;
  localparam int NUM_REGS_DEF     = 8;

  localparam logic [TIME_W-1:0]    TIME_MAX    = '1;
  localparam logic [RETIRED_W-1:0] RETIRED_MAX = '1;

  typedef struct packed {
    logic                 src_reg_valid;
    logic [REG_IDX_W-1:0] src_reg_index;
    logic                 src_mem_valid;
    logic [ADDR_W-1:0]    src_mem_addr;
    logic                 dst_reg_valid;
    logic [REG_IDX_W-1:0] dst_reg_index;
    logic                 dst_mem_valid;
    logic [ADDR_W-1:0]    dst_mem_addr;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]    issue_cycle;
    logic [TIME_W-1:0]    current_cycle;
    logic [RETIRED_W-1:0] retired_now;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN_SCAN,
    ST_SET_TARGET,
    ST_COMPACT,
    ST_SETTLE,
    ST_SRC_REG,
    ST_MEM_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic min_step;
    logic set_target;
    logic compact_step;
    logic settle;
    logic src_reg;
    logic mem_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic window_full;
    logic scan_last;
    logic slot_last;
    logic src_mem;
    logic result_free;
  } dp_status_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] x);
    return (x == TIME_MAX) ? TIME_MAX : x + TIME_W'(1);
  endfunction

  function automatic logic [TIME_W-1:0] max_time(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- hdl/its_ctrl.sv -----
// Sequencer for the issue timing scoreboard: window drain, source lookup, commit.
module its_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  its_pkg::dp_status_t    status,
  output its_pkg::ctrl_cmd_t     cmd
);

  its_pkg::state_t state;
  its_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= its_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      its_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = status.window_full ? its_pkg::ST_MIN_SCAN : its_pkg::ST_SRC_REG;
        end
      end
      its_pkg::ST_MIN_SCAN: begin
        if (status.scan_last) begin
          state_next = its_pkg::ST_SET_TARGET;
        end
      end
      its_pkg::ST_SET_TARGET: state_next = its_pkg::ST_COMPACT;
      its_pkg::ST_COMPACT: begin
        if (status.scan_last) begin
          state_next = its_pkg::ST_SETTLE;
        end
      end
      its_pkg::ST_SETTLE: state_next = its_pkg::ST_SRC_REG;
      its_pkg::ST_SRC_REG: begin
        state_next = status.src_mem ? its_pkg::ST_MEM_SCAN : its_pkg::ST_COMMIT;
      end
      its_pkg::ST_MEM_SCAN: begin
        if (status.slot_last) begin
          state_next = its_pkg::ST_COMMIT;
        end
      end
      its_pkg::ST_COMMIT: begin
        if (status.result_free) begin
          state_next = its_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      its_pkg::ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
      end
      its_pkg::ST_MIN_SCAN:   cmd.min_step     = 1'b1;
      its_pkg::ST_SET_TARGET: cmd.set_target   = 1'b1;
      its_pkg::ST_COMPACT:    cmd.compact_step = 1'b1;
      its_pkg::ST_SETTLE:     cmd.settle       = 1'b1;
      its_pkg::ST_SRC_REG:    cmd.src_reg      = 1'b1;
      its_pkg::ST_MEM_SCAN:   cmd.mem_step     = 1'b1;
      its_pkg::ST_COMMIT:     cmd.commit       = status.result_free;
    endcase
  end

endmodule

// ----- hdl/its_dp.sv -----
// Datapath: ready-time tables, issue window, cycle counter and result register.
`include "issue_timing_scoreboard_defines.svh"

module its_dp #(
  parameter int WINDOW_DEPTH = its_pkg::WINDOW_DEPTH_DEF,
  parameter int NUM_REGS     = its_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  its_pkg::ctrl_cmd_t            cmd,
  output its_pkg::dp_status_t           status,
  input  its_pkg::item_t                item,
  input  logic                          cfg_valid,
  input  logic [its_pkg::SLOT_W-1:0]    cfg_index,
  input  logic [its_pkg::ADDR_W-1:0]    cfg_data,
  output logic                          result_valid,
  input  logic                          result_ready,
  output its_pkg::result_t              result
);

  localparam int WIW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int RIW = $clog2(NUM_REGS);

  localparam logic [FW-1:0]  FILL_FULL = FW'(WINDOW_DEPTH);
  localparam logic [WIW-1:0] SCAN_LAST = WIW'(WINDOW_DEPTH - 1);

  // architectural state
  logic [its_pkg::ADDR_W-1:0] tag       [its_pkg::MEM_SLOTS];
  logic [its_pkg::TIME_W-1:0] reg_ready [NUM_REGS];
  logic [its_pkg::TIME_W-1:0] mem_ready [its_pkg::MEM_SLOTS];
  logic [its_pkg::TIME_W-1:0] win       [WINDOW_DEPTH];
  logic [FW-1:0]              fill;
  logic [its_pkg::TIME_W-1:0] cycle;

  // per-item working registers
  logic [WIW-1:0]                scan_i;
  logic [FW-1:0]                 kept;
  logic [its_pkg::SLOT_W-1:0]    slot;
  logic [its_pkg::TIME_W-1:0]    lowest;
  logic [its_pkg::TIME_W-1:0]    issue;
  logic [its_pkg::RETIRED_W-1:0] retired;

  logic                       sr_use;
  logic [RIW-1:0]             sr_idx;
  logic                       sm_use;
  logic [its_pkg::ADDR_W-1:0] sm_addr;
  logic                       dr_use;
  logic [RIW-1:0]             dr_idx;
  logic                       dm_use;
  logic [its_pkg::ADDR_W-1:0] dm_addr;

  logic [its_pkg::TIME_W-1:0]    target;
  logic [its_pkg::TIME_W-1:0]    ready_time;
  logic [its_pkg::TIME_W-1:0]    win_rd;
  logic                          keep_entry;
  logic [FW-1:0]                 kept_eff;
  logic [FW-1:0]                 drained;
  logic [its_pkg::RETIRED_W-1:0] retired_sat;
  logic [its_pkg::TIME_W-1:0]    reg_src;

  assign win_rd     = win[scan_i];
  assign keep_entry = !(win_rd < cycle);
  assign target     = its_pkg::max_time(its_pkg::sat_inc(cycle), its_pkg::sat_inc(lowest));
  assign ready_time = its_pkg::sat_inc(issue);
  assign reg_src    = sr_use ? reg_ready[sr_idx] : '0;

  // nothing retired means the cycle is pinned at its maximum: drop the whole window
  assign kept_eff    = (kept == FILL_FULL) ? '0 : kept;
  assign drained     = FILL_FULL - kept_eff;
  assign retired_sat = (32'(drained) > 32'(its_pkg::RETIRED_MAX)) ? its_pkg::RETIRED_MAX
                                                                 : its_pkg::RETIRED_W'(drained);

  assign status.window_full = (fill == FILL_FULL);
  assign status.scan_last   = (scan_i == SCAN_LAST);
  assign status.slot_last   = (slot == its_pkg::SLOT_W'(its_pkg::MEM_SLOTS - 1));
  assign status.src_mem     = sm_use;
  assign status.result_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < its_pkg::MEM_SLOTS; k++) begin
        tag[k]       <= '0;
        mem_ready[k] <= '0;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        reg_ready[r] <= '0;
      end
      fill         <= '0;
      cycle        <= '0;
      scan_i       <= '0;
      kept         <= '0;
      slot         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tag[cfg_index] <= cfg_data;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.load_item) begin
        scan_i <= '0;
        kept   <= '0;
      end
      if (cmd.min_step) begin
        scan_i <= scan_i + WIW'(1);
      end
      if (cmd.set_target) begin
        cycle  <= target;
        scan_i <= '0;
      end
      if (cmd.compact_step) begin
        scan_i <= scan_i + WIW'(1);
        if (keep_entry) begin
          kept <= kept + FW'(1);
        end
      end
      if (cmd.settle) begin
        fill <= kept_eff;
      end
      if (cmd.src_reg) begin
        slot <= '0;
      end
      if (cmd.mem_step) begin
        slot <= slot + its_pkg::SLOT_W'(1);
      end
      if (cmd.commit) begin
        if (dr_use) begin
          reg_ready[dr_idx] <= ready_time;
        end
        for (int k = 0; k < its_pkg::MEM_SLOTS; k++) begin
          if (dm_use && (tag[k] == dm_addr)) begin
            mem_ready[k] <= ready_time;
          end
        end
        fill         <= fill + FW'(1);
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sr_use  <= item.src_reg_valid && (32'(item.src_reg_index) < NUM_REGS);
      sr_idx  <= RIW'(item.src_reg_index);
      sm_use  <= item.src_mem_valid;
      sm_addr <= item.src_mem_addr;
      dr_use  <= item.dst_reg_valid && (32'(item.dst_reg_index) < NUM_REGS);
      dr_idx  <= RIW'(item.dst_reg_index);
      dm_use  <= item.dst_mem_valid;
      dm_addr <= item.dst_mem_addr;
      lowest  <= its_pkg::TIME_MAX;
      retired <= '0;
    end
    if (cmd.min_step && (win_rd < lowest)) begin
      lowest <= win_rd;
    end
    // in-place compaction: write slot never runs ahead of read slot
    if (cmd.compact_step && keep_entry) begin
      win[kept[WIW-1:0]] <= win_rd;
    end
    if (cmd.settle) begin
      retired <= retired_sat;
    end
    if (cmd.src_reg) begin
      issue <= its_pkg::max_time(cycle, reg_src);
    end
    if (cmd.mem_step && sm_use && (tag[slot] == sm_addr) && (mem_ready[slot] > issue)) begin
      issue <= mem_ready[slot];
    end
    if (cmd.commit) begin
      win[fill[WIW-1:0]]   <= issue;
      result.issue_cycle   <= issue;
      result.current_cycle <= cycle;
      result.retired_now   <= retired;
    end
  end

  `ITS_ASSERT_NEXT(a_target_advances, clk, rst, cmd.set_target, (cycle > $past(cycle)) || (cycle == its_pkg::TIME_MAX), "drain did not advance the cycle")
  `ITS_ASSERT_NEXT(a_settle_frees_slot, clk, rst, cmd.settle, fill < FILL_FULL, "drain left the window full")
  `ITS_ASSERT_NEXT(a_commit_posts, clk, rst, cmd.commit, result_valid && (fill == $past(fill) + FW'(1)), "commit did not post a result and append")

endmodule

// ----- hdl/issue_timing_scoreboard.sv -----
// Issue timing scoreboard: per instruction, computes the issue cycle from
// register and tracked-memory ready times, the cycle counter and a bounded
// issue window. One item is processed at a time by a sequencer. With room in
// the window an item passes through the source-register lookup and the
// commit, plus a memory scan when it reads memory (the eight tracked
// locations are compared one per cycle). When the window is full, a drain
// runs first: one pass over the window finds the oldest entry, a second pass
// compacts the window. The next item may be transferred while a result
// waits in the output register. Tag registers are written through the cfg
// channel, which is always ready; write them only while the block is idle.
module issue_timing_scoreboard #(
  parameter int WINDOW_DEPTH = its_pkg::WINDOW_DEPTH_DEF,
  parameter int NUM_REGS     = its_pkg::NUM_REGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  its_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output its_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [its_pkg::SLOT_W-1:0] cfg_index,
  input  logic [its_pkg::ADDR_W-1:0] cfg_data
);

  its_pkg::ctrl_cmd_t  cmd;
  its_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  its_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  its_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .NUM_REGS     (NUM_REGS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
